>>> rtl/core/bads_pkg.sv
// Shared types and constants for the box-average image downscaler.
package bads_pkg;

    // Field and register widths
    localparam int PIX_W      = 8;
    localparam int LANES      = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SF_W       = 5;
    localparam int FMT_W      = 2;
    localparam int IW_W       = 13;
    localparam int IH_W       = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_FACTOR = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_FORMAT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd3;

    // Pixel formats
    typedef enum logic [FMT_W-1:0] {
        FMT_GRAY8  = 2'd0,
        FMT_GRAY16 = 2'd1,
        FMT_RGB24  = 2'd2,
        FMT_RGBA32 = 2'd3
    } pix_fmt_t;

    // Register reset values
    localparam logic [SF_W-1:0] SF_RESET  = 5'd2;
    localparam pix_fmt_t        FMT_RESET = FMT_GRAY8;
    localparam logic [IW_W-1:0] IW_RESET  = 13'd640;
    localparam logic [IH_W-1:0] IH_RESET  = 16'd480;

    // Quotient bits developed per block: one per divider step
    localparam int GRAY16_STEPS = 16;
    localparam int BYTE_STEPS   = 8;
    localparam int STEP_CNT_W   = 5;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    // Flags that travel with a finished block
    typedef struct packed {
        logic     row_end;
        logic     frame_end;
        pix_fmt_t fmt;
    } blk_tag_t;

endpackage

>>> rtl/core/bads_divider.sv
// Radix-2 restoring divider that turns four block sums into their averages.
module bads_divider
    import bads_pkg::*;
#(
    parameter int LW = 16,
    parameter int DW = 9
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DW-1:0]            divisor,
    input  logic [LANES*LW-1:0]      sum,
    input  blk_tag_t                 tag_in,
    output logic                     busy,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic [LANES*PIX_W-1:0]   res_data,
    output blk_tag_t                 res_tag
);

    localparam int QW = 2 * PIX_W;

    div_state_t            state_reg, state_next;
    logic [STEP_CNT_W-1:0] step_reg, step_next;
    logic [STEP_CNT_W-1:0] last_step;
    logic [DW-1:0]         divisor_reg;
    blk_tag_t              tag_reg;
    logic [DW-1:0]         rem_reg  [LANES];
    logic [DW-1:0]         rem_next [LANES];
    logic [QW-1:0]         quo_reg  [LANES];
    logic [QW-1:0]         quo_next [LANES];
    logic [2*LW-1:0]       dividend [LANES];
    logic [DW:0]           trial    [LANES];
    logic                  fits     [LANES];
    logic                  gray16_in;

    assign gray16_in = (tag_in.fmt == FMT_GRAY16);
    assign last_step = (tag_reg.fmt == FMT_GRAY16) ? STEP_CNT_W'(GRAY16_STEPS - 1)
                                                   : STEP_CNT_W'(BYTE_STEPS - 1);

    // Lane operands; gray16 treats the two low lanes as one sum
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (k == 0 && gray16_in)
                dividend[k] = sum[2*LW-1:0];
            else
                dividend[k] = {{LW{1'b0}}, sum[k*LW +: LW]};
            trial[k] = {rem_reg[k], quo_reg[k][QW-1]};
            fits[k]  = (trial[k] >= {1'b0, divisor_reg});
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state and datapath steps
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        for (int k = 0; k < LANES; k++)
        begin
            rem_next[k] = rem_reg[k];
            quo_next[k] = quo_reg[k];
        end
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    state_next = DIV_RUN;
                    step_next  = '0;
                    // Quotient is known to fit, so the high part starts as remainder
                    for (int k = 0; k < LANES; k++)
                    begin
                        if (gray16_in)
                        begin
                            rem_next[k] = DW'(dividend[k] >> QW);
                            quo_next[k] = dividend[k][QW-1:0];
                        end
                        else
                        begin
                            rem_next[k] = DW'(dividend[k] >> PIX_W);
                            quo_next[k] = {dividend[k][PIX_W-1:0], {PIX_W{1'b0}}};
                        end
                    end
                end
            end
            DIV_RUN:
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    rem_next[k] = fits[k] ? DW'(trial[k] - {1'b0, divisor_reg})
                                          : DW'(trial[k]);
                    quo_next[k] = {quo_reg[k][QW-2:0], fits[k]};
                end
                step_next = step_reg + STEP_CNT_W'(1);
                if (step_reg == last_step)
                    state_next = DIV_DONE;
            end
            DIV_DONE:
            begin
                if (res_ready)
                    state_next = DIV_IDLE;
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    // Operand and lane registers
    always_ff @(posedge clk)
    begin
        if (state_reg == DIV_IDLE && start)
        begin
            divisor_reg <= divisor;
            tag_reg     <= tag_in;
        end
        for (int k = 0; k < LANES; k++)
        begin
            rem_reg[k] <= rem_next[k];
            quo_reg[k] <= quo_next[k];
        end
    end

    // Place quotients by format; unused channels read zero
    always_comb
    begin
        res_data = '0;
        case (tag_reg.fmt)
            FMT_GRAY8:
                res_data[PIX_W-1:0] = quo_reg[0][PIX_W-1:0];
            FMT_GRAY16:
                res_data[QW-1:0] = quo_reg[0];
            FMT_RGB24:
            begin
                for (int k = 0; k < 3; k++)
                    res_data[k*PIX_W +: PIX_W] = quo_reg[k][PIX_W-1:0];
            end
            FMT_RGBA32:
            begin
                for (int k = 0; k < LANES; k++)
                    res_data[k*PIX_W +: PIX_W] = quo_reg[k][PIX_W-1:0];
            end
            default:
                res_data = '0;
        endcase
    end

    assign busy      = (state_reg != DIV_IDLE);
    assign res_valid = (state_reg == DIV_DONE);
    assign res_tag   = tag_reg;

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == DIV_IDLE)
        else $error("divider started while busy");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DIV_RUN |-> step_reg <= last_step)
        else $error("divider step count ran past its last step");

    a_done_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DIV_DONE |-> $past(state_reg) == DIV_RUN || $past(state_reg) == DIV_DONE)
        else $error("divider reached done without running");

endmodule

>>> rtl/core/box_average_image_downscaler_top.sv
// Path: a block's last pixel is registered in the accumulate stage, then starts the divider,
// whose result is registered at the output; divider steps are 8 for gray8, 24-bit and 32-bit
// formats and 16 for gray16. Throughput: one pixel per cycle, except that the last pixel of each
// block holds s_tready low until the shared bit-serial divider's averages move to the output.
// Reset: rst_n clears position counters, pipeline valids and configuration registers to their defaults;
// the column sum memory is not cleared, since each entry is written before it is read.
module box_average_image_downscaler_top
    import bads_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_FACTOR = 16
)(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration write port
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    // pixel input
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [LANES*PIX_W-1:0]   s_tdata,   // chan0, chan1, chan2, chan3
    // averaged pixel output
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [LANES*PIX_W-1:0]   m_tdata,   // avg0, avg1, avg2, avg3
    output logic                     m_tlast,   // row_end
    output logic                     m_tuser    // frame_end
);

    localparam int FB  = $clog2(MAX_FACTOR);
    localparam int FW  = $clog2(MAX_FACTOR + 1);
    localparam int LW  = PIX_W + 2 * FB;
    localparam int EW  = LANES * LW;
    localparam int DW  = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CXW = $clog2(MAX_WIDTH + 3 * MAX_FACTOR + 1);
    localparam int RXW = $clog2((1 << IH_W) + 3 * MAX_FACTOR + 1);

    // Configuration registers
    logic [SF_W-1:0] sf_reg;
    pix_fmt_t        fmt_reg;
    logic [IW_W-1:0] iw_reg;
    logic [IH_W-1:0] ih_reg;

    // Effective geometry
    logic [FW-1:0]   f_eff;
    logic [WW-1:0]   w_eff;
    logic [IH_W-1:0] h_eff;
    logic [DW-1:0]   f_sq;
    logic [DW-1:0]   d_reg;
    logic [CXW-1:0]  fx;
    logic [RXW-1:0]  fy;

    // Position counters
    logic [WW-1:0]   col_cnt_reg, col_cnt_next;
    logic [IH_W-1:0] row_cnt_reg, row_cnt_next;
    logic [FB-1:0]   cib_reg, cib_next;
    logic [FB-1:0]   rib_reg, rib_next;
    logic [AW-1:0]   out_col_reg, out_col_next;
    logic [CXW-1:0]  col_base_reg, col_base_next;
    logic [RXW-1:0]  row_base_reg, row_base_next;

    // Position decode
    logic            accept;
    logic            col_fit, row_fit, col_last, row_last;
    logic            cib_last, rib_last, col_end, row_end_px;
    logic            blk_whole, blk_first, blk_final;
    logic [EW-1:0]   addend;

    // Accumulate stage
    logic            s2_valid_reg;
    logic            s2_we_reg;
    logic            s2_first_reg;
    logic            s2_final_reg;
    logic [AW-1:0]   s2_addr_reg;
    logic [EW-1:0]   s2_addend_reg;
    blk_tag_t        s2_tag_reg;
    logic [EW-1:0]   s2_sum;
    logic            s2_write;
    logic [EW-1:0]   rd_reg;
    logic [EW-1:0]   sum_mem [MAX_WIDTH];

    // Divider and output register
    logic                    div_busy;
    logic                    res_valid;
    logic                    res_ready;
    logic [LANES*PIX_W-1:0]  res_data;
    blk_tag_t                res_tag;
    logic                    out_valid_reg;
    logic [LANES*PIX_W-1:0]  out_data_reg;
    logic                    out_last_reg;
    logic                    out_user_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_reg  <= SF_RESET;
            fmt_reg <= FMT_RESET;
            iw_reg  <= IW_RESET;
            ih_reg  <= IH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SCALE_FACTOR: sf_reg  <= cfg_data[SF_W-1:0];
                REG_PIXEL_FORMAT: fmt_reg <= pix_fmt_t'(cfg_data[FMT_W-1:0]);
                REG_IMAGE_WIDTH:  iw_reg  <= cfg_data[IW_W-1:0];
                REG_IMAGE_HEIGHT: ih_reg  <= cfg_data[IH_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp geometry to the supported range
    always_comb
    begin
        if (sf_reg == '0)
            f_eff = FW'(1);
        else if (32'(sf_reg) > MAX_FACTOR)
            f_eff = FW'(MAX_FACTOR);
        else
            f_eff = FW'(sf_reg);

        if (iw_reg == '0)
            w_eff = WW'(1);
        else if (32'(iw_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(iw_reg);

        h_eff = (ih_reg == '0) ? IH_W'(1) : ih_reg;
    end

    assign fx   = CXW'(f_eff);
    assign fy   = RXW'(f_eff);
    assign f_sq = DW'(f_eff) * DW'(f_eff);

    // Block size for the divider
    always_ff @(posedge clk)
    begin
        d_reg <= f_sq;
    end

    // Locate the incoming pixel within its block and the frame
    assign accept     = s_tvalid && s_tready;
    assign col_fit    = (col_base_reg + fx) <= CXW'(w_eff);
    assign col_last   = (col_base_reg + (fx << 1)) > CXW'(w_eff);
    assign row_fit    = (row_base_reg + fy) <= RXW'(h_eff);
    assign row_last   = (row_base_reg + (fy << 1)) > RXW'(h_eff);
    assign cib_last   = (FW'(cib_reg) + FW'(1)) == f_eff;
    assign rib_last   = (FW'(rib_reg) + FW'(1)) == f_eff;
    assign col_end    = (col_cnt_reg + WW'(1)) >= w_eff;
    assign row_end_px = ({1'b0, row_cnt_reg} + (IH_W + 1)'(1)) >= {1'b0, h_eff};
    assign blk_whole  = col_fit && row_fit;
    assign blk_first  = (cib_reg == '0) && (rib_reg == '0);
    assign blk_final  = blk_whole && cib_last && rib_last;

    // Spread the pixel over the sum lanes; gray16 is one 16-bit value
    always_comb
    begin
        addend = '0;
        if (fmt_reg == FMT_GRAY16)
            addend = EW'(s_tdata[2*PIX_W-1:0]);
        else
        begin
            for (int k = 0; k < LANES; k++)
                addend[k*LW +: LW] = LW'(s_tdata[k*PIX_W +: PIX_W]);
        end
    end

    // Advance position counters; any register write restarts the frame
    always_comb
    begin
        col_cnt_next  = col_cnt_reg;
        row_cnt_next  = row_cnt_reg;
        cib_next      = cib_reg;
        rib_next      = rib_reg;
        out_col_next  = out_col_reg;
        col_base_next = col_base_reg;
        row_base_next = row_base_reg;
        if (cfg_we)
        begin
            col_cnt_next  = '0;
            row_cnt_next  = '0;
            cib_next      = '0;
            rib_next      = '0;
            out_col_next  = '0;
            col_base_next = '0;
            row_base_next = '0;
        end
        else if (accept)
        begin
            if (cib_last)
            begin
                cib_next      = '0;
                out_col_next  = out_col_reg + AW'(1);
                col_base_next = col_base_reg + fx;
            end
            else
                cib_next = cib_reg + FB'(1);

            if (col_end)
            begin
                col_cnt_next  = '0;
                cib_next      = '0;
                out_col_next  = '0;
                col_base_next = '0;
                if (rib_last)
                begin
                    rib_next      = '0;
                    row_base_next = row_base_reg + fy;
                end
                else
                    rib_next = rib_reg + FB'(1);
                if (row_end_px)
                begin
                    row_cnt_next  = '0;
                    rib_next      = '0;
                    row_base_next = '0;
                end
                else
                    row_cnt_next = row_cnt_reg + IH_W'(1);
            end
            else
                col_cnt_next = col_cnt_reg + WW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            cib_reg      <= '0;
            rib_reg      <= '0;
            out_col_reg  <= '0;
            col_base_reg <= '0;
            row_base_reg <= '0;
        end
        else
        begin
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            cib_reg      <= cib_next;
            rib_reg      <= rib_next;
            out_col_reg  <= out_col_next;
            col_base_reg <= col_base_next;
            row_base_reg <= row_base_next;
        end
    end

    // Accumulate stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= accept;
    end

    // Accumulate stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_we_reg               <= blk_whole;
            s2_first_reg            <= blk_first;
            s2_final_reg            <= blk_final;
            s2_addr_reg             <= out_col_reg;
            s2_addend_reg           <= addend;
            s2_tag_reg.row_end      <= col_last;
            s2_tag_reg.frame_end    <= col_last && row_last;
            s2_tag_reg.fmt          <= fmt_reg;
        end
    end

    // Byte lanes never carry into each other and gray16 spans the two low lanes, so one wide add serves all formats
    assign s2_sum   = s2_first_reg ? s2_addend_reg : rd_reg + s2_addend_reg;
    assign s2_write = s2_valid_reg && s2_we_reg;

    // Column sum memory; forward the write when the next pixel reads the same column
    always_ff @(posedge clk)
    begin
        if (s2_write)
            sum_mem[s2_addr_reg] <= s2_sum;
        if (s2_write && s2_addr_reg == out_col_reg)
            rd_reg <= s2_sum;
        else
            rd_reg <= sum_mem[out_col_reg];
    end

    // Hold input while a finished block waits for or occupies the divider
    assign s_tready = !(s2_valid_reg && s2_final_reg) && !div_busy;

    bads_divider #(
        .LW (LW),
        .DW (DW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s2_valid_reg && s2_final_reg),
        .divisor   (d_reg),
        .sum       (s2_sum),
        .tag_in    (s2_tag_reg),
        .busy      (div_busy),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .res_tag   (res_tag)
    );

    // Output register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res_data;
            out_last_reg <= res_tag.row_end;
            out_user_reg <= res_tag.frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    a_final_finds_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_final_reg |-> !div_busy)
        else $error("block completed while divider busy");

    a_pos_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        FW'(cib_reg) < f_eff && FW'(rib_reg) < f_eff)
        else $error("position within block exceeds factor");

    a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(div_busy) |-> $past(s2_valid_reg && s2_final_reg))
        else $error("divider started without a completed block");

endmodule
